// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by lbp_3x3_operator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int WIDTH_RESET  = 192;
    localparam int HEIGHT_RESET = 168;

    typedef logic [PIX_W-1:0]          pix_t;
    // one window column: [0] top, [1] middle, [2] bottom
    typedef logic [2:0][PIX_W-1:0]     pix_col_t;
    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_idx_t;

    // per-request pipeline tag
    typedef struct packed {
        logic valid;
        logic produce;
        logic frame_end;
    } lbp_tag_t;

    // last column index of a row, width clamped to 3..MAX_WIDTH
    function automatic col_t last_col(input logic [WIDTH_REG_W-1:0] w);
        logic [WIDTH_REG_W-1:0] t;
        if (w < WIDTH_REG_W'(3))
            t = WIDTH_REG_W'(3);
        else if (w > WIDTH_REG_W'(MAX_WIDTH))
            t = WIDTH_REG_W'(MAX_WIDTH);
        else
            t = w;
        return col_t'(t - WIDTH_REG_W'(1));
    endfunction

    // last row index of a frame, height clamped to 3..HEIGHT_LIMIT
    function automatic row_t last_row(input logic [HEIGHT_REG_W-1:0] h);
        logic [HEIGHT_REG_W-1:0] t;
        if (h < HEIGHT_REG_W'(3))
            t = HEIGHT_REG_W'(3);
        else if (h > HEIGHT_REG_W'(HEIGHT_LIMIT))
            t = HEIGHT_REG_W'(HEIGHT_LIMIT);
        else
            t = h;
        return row_t'(t - HEIGHT_REG_W'(1));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lbp_3x3_operator.sv =====
// An accepted pixel passes the stage-1 registers, window cells and output
// skid to m_axis_tvalid; one pixel per cycle while the skid has room.
// A two-entry output skid keeps input flowing while a code waits.
// Reset (rst_n, async, active low) clears counters, pipeline and window;
// width and height reset to 192 and 168. Line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lbp_3x3_operator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,  // [7:0] pixel
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [7:0]                            m_axis_tdata,  // [7:0] lbp_code
    output logic                                  m_axis_tlast,  // frame_end
    input  wire logic                             cfg_wr_en,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lbp_pkg::*;

    col_t     last_col_reg;
    row_t     last_row_reg;
    col_t     col_reg;
    col_t     col_next;
    row_t     row_reg;
    row_t     row_next;
    logic     cfg_restart;
    logic     adv;
    logic     accept;
    logic     produce0;
    logic     frame_end0;
    lbp_tag_t s1_tag_reg;
    pix_t     s1_pixel_reg;
    lbp_tag_t s2_tag_reg;
    pix_t     top_q;
    pix_t     mid_q;
    pix_col_t col_new;
    pix_col_t win_q [3];
    pix_t     center;
    pix_t     code;
    logic     push;
    logic     pop;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    pix_t     head_code_reg;
    pix_t     head_code_next;
    logic     head_last_reg;
    logic     head_last_next;
    pix_t     tail_code_reg;
    pix_t     tail_code_next;
    logic     tail_last_reg;
    logic     tail_last_next;

    // configuration decode: known registers restart the frame
    always_comb
    begin
        unique case (cfg_index)
            CFG_IMAGE_WIDTH:  cfg_restart = cfg_wr_en;
            CFG_IMAGE_HEIGHT: cfg_restart = cfg_wr_en;
            default:          cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= last_col(WIDTH_REG_W'(WIDTH_RESET));
            last_row_reg <= last_row(HEIGHT_REG_W'(HEIGHT_RESET));
        end
        else if (cfg_wr_en && cfg_index == CFG_IMAGE_WIDTH)
        begin
            last_col_reg <= last_col(cfg_data[WIDTH_REG_W-1:0]);
        end
        else if (cfg_wr_en && cfg_index == CFG_IMAGE_HEIGHT)
        begin
            last_row_reg <= last_row(cfg_data[HEIGHT_REG_W-1:0]);
        end
    end

    // handshake: the pipeline moves whenever the skid has room
    assign adv           = (cnt_reg != 2'd2);
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // raster position of the incoming pixel
    assign produce0   = (row_reg >= row_t'(2)) && (col_reg >= col_t'(2));
    assign frame_end0 = (row_reg == last_row_reg) && (col_reg == last_col_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + row_t'(1);
            end
            else
            begin
                col_next = col_reg + col_t'(1);
            end
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores
    lbp_line_buf u_line_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .rd_req (accept),
        .addr   (col_reg),
        .pixel  (s_axis_tdata),
        .top_q  (top_q),
        .mid_q  (mid_q)
    );

    // stage 1 tag and pixel, in step with the line store read, and stage 2 tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= '{valid: accept, produce: produce0, frame_end: frame_end0};
            s2_tag_reg <= '{valid:     s1_tag_reg.valid && s1_tag_reg.produce,
                            produce:   s1_tag_reg.produce,
                            frame_end: s1_tag_reg.frame_end};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= s_axis_tdata;
        end
    end

    // window: chain of three column cells, newest column enters at cell 2
    assign col_new[0] = top_q;
    assign col_new[1] = mid_q;
    assign col_new[2] = s1_pixel_reg;

    for (genvar g = 0; g < 3; g++)
    begin : g_win
        if (g == 2)
        begin : g_head
            lbp_win_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (adv && s1_tag_reg.valid),
                .col_in (col_new),
                .col_q  (win_q[g])
            );
        end
        else
        begin : g_body
            lbp_win_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (adv && s1_tag_reg.valid),
                .col_in (win_q[g+1]),
                .col_q  (win_q[g])
            );
        end
    end

    // neighbor-greater compare, bit 7 top-left clockwise to bit 0 left
    assign center  = win_q[1][1];
    assign code[7] = win_q[0][0] > center;
    assign code[6] = win_q[1][0] > center;
    assign code[5] = win_q[2][0] > center;
    assign code[4] = win_q[2][1] > center;
    assign code[3] = win_q[2][2] > center;
    assign code[2] = win_q[1][2] > center;
    assign code[1] = win_q[0][2] > center;
    assign code[0] = win_q[0][1] > center;

    // two-entry output skid
    assign push = adv && s2_tag_reg.valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        cnt_next       = cnt_reg;
        head_code_next = head_code_reg;
        head_last_next = head_last_reg;
        tail_code_next = tail_code_reg;
        tail_last_next = tail_last_reg;
        priority if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_code_next = code;
                head_last_next = s2_tag_reg.frame_end;
            end
            else
            begin
                head_code_next = tail_code_reg;
                head_last_next = tail_last_reg;
                tail_code_next = code;
                tail_last_next = s2_tag_reg.frame_end;
            end
        end
        else if (push)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd0)
            begin
                head_code_next = code;
                head_last_next = s2_tag_reg.frame_end;
            end
            else
            begin
                tail_code_next = code;
                tail_last_next = s2_tag_reg.frame_end;
            end
        end
        else if (pop)
        begin
            cnt_next       = cnt_reg - 2'd1;
            head_code_next = tail_code_reg;
            head_last_next = tail_last_reg;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_code_reg <= head_code_next;
        head_last_reg <= head_last_next;
        tail_code_reg <= tail_code_next;
        tail_last_reg <= tail_last_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = head_code_reg;
    assign m_axis_tlast  = head_last_reg;

    // checks
    `ASSERT_ALWAYS(a_skid_bound, clk, cnt_reg != 2'd3, "output skid overflow")
    `ASSERT_AR(a_col_in_row, clk, rst_n, col_reg <= last_col_reg, "column past row end")
    `ASSERT_AR(a_frame_wrap, clk, rst_n, (accept && frame_end0 && !cfg_restart) |=> (col_reg == '0 && row_reg == '0), "frame did not wrap")

endmodule
`default_nettype wire

// ===== rtl/lbp_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbp_line_buf (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         rd_req,
    input  wire lbp_pkg::col_t addr,
    input  wire lbp_pkg::pix_t pixel,
    output lbp_pkg::pix_t     top_q,
    output lbp_pkg::pix_t     mid_q
);
    import lbp_pkg::*;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t top_q_reg;
    pix_t mid_q_reg;
    col_t wb_addr_reg;
    logic wb_en_reg;

    // read both rows, push the new pixel into the middle row
    always_ff @(posedge clk)
    begin
        if (adv && rd_req)
        begin
            top_q_reg          <= upper_mem[addr];
            mid_q_reg          <= middle_mem[addr];
            middle_mem[addr]   <= pixel;
        end
    end

    // the old middle entry, registered in mid_q_reg, then moves up
    always_ff @(posedge clk)
    begin
        if (adv && wb_en_reg)
        begin
            upper_mem[wb_addr_reg] <= mid_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && rd_req)
        begin
            wb_addr_reg <= addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_en_reg <= 1'b0;
        end
        else if (adv)
        begin
            wb_en_reg <= rd_req;
        end
    end

    assign top_q = top_q_reg;
    assign mid_q = mid_q_reg;

endmodule
`default_nettype wire

// ===== rtl/lbp_win_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbp_win_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire lbp_pkg::pix_col_t col_in,
    output lbp_pkg::pix_col_t      col_q
);
    import lbp_pkg::*;

    pix_col_t col_reg;

    // hold one window column, take the neighbor's column on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_q = col_reg;

endmodule
`default_nettype wire
